FILE: rtl/sbrs_pkg.sv
// shared types and constants for the sequence bank reference scanner
package sbrs_pkg;

    // command counter width and the command limit
    localparam int CNT_W = 19;
    localparam logic [CNT_W-1:0] MAX_COMMANDS = CNT_W'(262144);

    // bank set size
    localparam int BANKS      = 128;
    localparam int BANK_IDX_W = 7;
    localparam int MAP_W      = 64;

    // status bytes, status classes and the bank select controller
    localparam logic [7:0] STATUS_END   = 8'h83;
    localparam logic [7:0] STATUS_LONG  = 8'h81;
    localparam logic [7:0] STATUS_SHORT = 8'h82;
    localparam logic [3:0] HI_CTRL      = 4'hB;
    localparam logic [3:0] HI_PROG      = 4'hC;
    localparam logic [3:0] HI_PRESS     = 4'hD;
    localparam logic [3:0] HI_BEND      = 4'hE;
    localparam logic [7:0] CTRL_BANK    = 8'd32;

    // reason a scan stopped
    typedef enum logic [1:0] {
        CAUSE_REGION = 2'd0,
        CAUSE_MARKER = 2'd1,
        CAUSE_TRUNC  = 2'd2,
        CAUSE_LIMIT  = 2'd3
    } stop_cause_t;

    // one stream byte with its side flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       scan_start;
        logic       in_region;
        logic       data_last;
    } item_t;

    // scan summary
    typedef struct packed {
        logic [MAP_W-1:0] bank_map_low;
        logic [MAP_W-1:0] bank_map_high;
        logic [CNT_W-1:0] commands_seen;
        stop_cause_t      stop_cause;
    } result_t;

endpackage

FILE: rtl/sbrs_input_stage.sv
// input register stage for the stream bytes
module sbrs_input_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  sbrs_pkg::item_t item,
    input  logic           take,
    output logic           stage_valid,
    output sbrs_pkg::item_t stage_item
);

    logic            valid_reg;
    sbrs_pkg::item_t item_reg;

    // room when empty or when the held byte leaves this cycle
    assign item_ready  = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    // payload capture on transfer
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

FILE: rtl/sbrs_scan_core.sv
// command splitter, bank set and scan state
module sbrs_scan_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sbrs_pkg::item_t   item,
    output logic              res_fire,
    output sbrs_pkg::result_t res
);

    localparam logic [7:0] STATUS_END   = sbrs_pkg::STATUS_END;
    localparam logic [7:0] STATUS_LONG  = sbrs_pkg::STATUS_LONG;
    localparam logic [7:0] STATUS_SHORT = sbrs_pkg::STATUS_SHORT;
    localparam logic [3:0] HI_CTRL      = sbrs_pkg::HI_CTRL;
    localparam logic [3:0] HI_PROG      = sbrs_pkg::HI_PROG;
    localparam logic [3:0] HI_PRESS     = sbrs_pkg::HI_PRESS;
    localparam logic [3:0] HI_BEND      = sbrs_pkg::HI_BEND;
    localparam logic [7:0] CTRL_BANK    = sbrs_pkg::CTRL_BANK;

    // command length from its status byte
    function automatic logic [2:0] cmd_length(input logic [7:0] status);
        logic [2:0] len;
        begin
            len = 3'd1;
            if (!status[7])
                len = 3'd5;
            else if (status[7:4] == HI_CTRL)
                len = 3'd4;
            else if (status[7:4] == HI_PROG || status[7:4] == HI_PRESS
                     || status[7:4] == HI_BEND)
                len = 3'd3;
            else if (status == STATUS_LONG)
                len = 3'd4;
            else if (status == STATUS_SHORT)
                len = 3'd2;
            cmd_length = len;
        end
    endfunction

    logic [2:0]                     pos_reg, pos_next;
    logic [2:0]                     len_reg, len_next;
    logic                           cc_reg, cc_next;
    logic [7:0]                     ctrl_reg, ctrl_next;
    logic [sbrs_pkg::BANK_IDX_W-1:0] bank_reg, bank_next;
    logic [sbrs_pkg::BANKS-1:0]     set_reg, set_next;
    logic [sbrs_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           fin_reg, fin_next;
    sbrs_pkg::stop_cause_t          cause;

    // one byte of the scan
    always_comb
    begin
        logic [2:0] pos_inc;
        logic [2:0] status_len;

        // a start byte sees cleared state
        if (item.scan_start)
        begin
            pos_next  = '0;
            len_next  = '0;
            cc_next   = 1'b0;
            ctrl_next = '0;
            bank_next = '0;
            set_next  = '0;
            cnt_next  = '0;
            fin_next  = 1'b0;
        end
        else
        begin
            pos_next  = pos_reg;
            len_next  = len_reg;
            cc_next   = cc_reg;
            ctrl_next = ctrl_reg;
            bank_next = bank_reg;
            set_next  = set_reg;
            cnt_next  = cnt_reg;
            fin_next  = fin_reg;
        end

        res_fire   = 1'b0;
        cause      = sbrs_pkg::CAUSE_REGION;
        pos_inc    = pos_next + 3'd1;
        status_len = cmd_length(item.data_byte);

        if (!fin_next)
        begin
            if (pos_next == 3'd0)
            begin
                // byte where a command would start
                if (!item.in_region)
                begin
                    res_fire = 1'b1;
                    cause    = sbrs_pkg::CAUSE_REGION;
                end
                else if (cnt_next >= sbrs_pkg::MAX_COMMANDS)
                begin
                    res_fire = 1'b1;
                    cause    = sbrs_pkg::CAUSE_LIMIT;
                end
                else if (item.data_byte == STATUS_END)
                begin
                    res_fire = 1'b1;
                    cause    = sbrs_pkg::CAUSE_MARKER;
                end
                else if (status_len == 3'd1)
                begin
                    cnt_next = cnt_next + sbrs_pkg::CNT_W'(1);
                    len_next = '0;
                    cc_next  = 1'b0;
                    if (item.data_last)
                    begin
                        res_fire = 1'b1;
                        cause    = sbrs_pkg::CAUSE_REGION;
                    end
                end
                else
                begin
                    len_next  = status_len;
                    cc_next   = (item.data_byte[7:4] == HI_CTRL);
                    ctrl_next = '0;
                    bank_next = '0;
                    pos_next  = 3'd1;
                    if (item.data_last)
                    begin
                        res_fire = 1'b1;
                        cause    = sbrs_pkg::CAUSE_TRUNC;
                    end
                end
            end
            else
            begin
                // operand bytes
                if (pos_next == 3'd1)
                    ctrl_next = item.data_byte;
                else if (pos_next == 3'd2)
                    bank_next = item.data_byte[sbrs_pkg::BANK_IDX_W-1:0];

                if (pos_inc >= len_next)
                begin
                    if (cc_next && ctrl_next == CTRL_BANK)
                        set_next = set_next | (sbrs_pkg::BANKS'(1) << bank_next);
                    cnt_next = cnt_next + sbrs_pkg::CNT_W'(1);
                    pos_next = '0;
                    len_next = '0;
                    cc_next  = 1'b0;
                    if (item.data_last)
                    begin
                        res_fire = 1'b1;
                        cause    = sbrs_pkg::CAUSE_REGION;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                    if (item.data_last)
                    begin
                        res_fire = 1'b1;
                        cause    = sbrs_pkg::CAUSE_TRUNC;
                    end
                end
            end
        end

        if (res_fire)
            fin_next = 1'b1;
    end

    // summary of the stopped scan
    assign res.bank_map_low  = set_next[sbrs_pkg::MAP_W-1:0];
    assign res.bank_map_high = set_next[sbrs_pkg::BANKS-1:sbrs_pkg::MAP_W];
    assign res.commands_seen = cnt_next;
    assign res.stop_cause    = cause;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            cc_reg   <= 1'b0;
            ctrl_reg <= '0;
            bank_reg <= '0;
            set_reg  <= '0;
            cnt_reg  <= '0;
            fin_reg  <= 1'b1;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            cc_reg   <= cc_next;
            ctrl_reg <= ctrl_next;
            bank_reg <= bank_next;
            set_reg  <= set_next;
            cnt_reg  <= cnt_next;
            fin_reg  <= fin_next;
        end
    end

    // a scan that reported is finished
    a_fin_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_fire |=> fin_reg)
        else $error("scan not finished after its result");

    // inside a command the position stays below the length
    a_pos_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 3'd0 |-> pos_reg < len_reg)
        else $error("byte position past command length");

    // the counter never runs past the limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sbrs_pkg::MAX_COMMANDS)
        else $error("command counter past limit");

    // a limit stop reports exactly the limit
    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && res.stop_cause == sbrs_pkg::CAUSE_LIMIT
        |-> res.commands_seen == sbrs_pkg::MAX_COMMANDS)
        else $error("limit stop with wrong count");

endmodule

FILE: rtl/sequence_bank_reference_scan.sv
// top level of the sequence bank reference scanner
// Takes one stream byte per cycle and returns one summary per scan: a 128-bit bank map,
// the command count and the stop cause. Each byte passes an input register, then a
// combinational decode that updates the command state and the bank set, then the result
// register, from which the summary of the byte that ends the scan is offered. The decode
// sustains one byte per cycle; a held result stalls intake only when the byte in the input
// register would end a scan while the result register is still full.
module sequence_bank_reference_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sbrs_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sbrs_pkg::result_t result
);

    logic              stage_valid;
    sbrs_pkg::item_t   stage_item;
    logic              take;
    logic              res_fire;
    sbrs_pkg::result_t res;
    logic              result_valid_reg;
    sbrs_pkg::result_t result_reg;

    // the held byte is processed unless its summary finds the result register full
    assign take = stage_valid && (!res_fire || !result_valid_reg || result_ready);

    sbrs_input_stage u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    sbrs_scan_core u_scan_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (take),
        .item     (stage_item),
        .res_fire (res_fire),
        .res      (res)
    );

    // result register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || result_ready)
        begin
            result_valid_reg <= take && res_fire;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && res_fire)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/sequence_bank_reference_scan_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the sequence bank reference scanner
module sequence_bank_reference_scan_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1460;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // status bytes and controller numbers with a meaning of their own
    localparam logic [7:0] ST_END_MARKER    = sbrs_pkg::STATUS_END;
    localparam logic [7:0] ST_LONG_CMD      = sbrs_pkg::STATUS_LONG;
    localparam logic [7:0] ST_SHORT_CMD     = sbrs_pkg::STATUS_SHORT;
    localparam logic [7:0] ST_LAST_NOTE     = 8'h7F;
    localparam logic [3:0] HI_CTRL          = sbrs_pkg::HI_CTRL;
    localparam logic [3:0] HI_PROG          = sbrs_pkg::HI_PROG;
    localparam logic [3:0] HI_PRESS         = sbrs_pkg::HI_PRESS;
    localparam logic [3:0] HI_BEND          = sbrs_pkg::HI_BEND;
    localparam logic [7:0] BANK_SELECT_CTRL = sbrs_pkg::CTRL_BANK;

    typedef enum {CMD_NOTE, CMD_CTRL, CMD_BANK, CMD_THREE, CMD_LONG, CMD_SHORT, CMD_SINGLE}
        cmd_kind_t;
    typedef enum {END_MARKER, END_REGION, END_AT_LAST, END_TRUNC, END_RESTART} scan_end_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    sbrs_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    sbrs_pkg::result_t result;

    sequence_bank_reference_scan dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #CLK_HALF clk = ~clk;

    // traffic shaping, changed per phase
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    logic hold_active = 1'b0;

    // scan state of the predictor
    logic [2:0]   sp_pos   = '0;
    logic [2:0]   sp_len   = '0;
    logic         sp_is_cc = 1'b0;
    logic [7:0]   sp_ctrl  = '0;
    logic [6:0]   sp_bank  = '0;
    logic [127:0] sp_banks = '0;
    int unsigned  sp_count = 0;
    logic         sp_done  = 1'b1;

    sbrs_pkg::result_t pending_summaries[$];

    int unsigned bytes_live   = 0;
    int unsigned scans_closed = 0;
    int unsigned cause_hits[4];
    int unsigned n_errors     = 0;

    function automatic sbrs_pkg::item_t make_item(logic [7:0] b, logic s, logic r, logic l);
        sbrs_pkg::item_t it;
        it.data_byte  = b;
        it.scan_start = s;
        it.in_region  = r;
        it.data_last  = l;
        return it;
    endfunction

    // command length from its status byte
    function automatic logic [2:0] command_bytes(logic [7:0] st);
        if (st <= ST_LAST_NOTE)
            return 3'd5;
        if (st[7:4] == HI_CTRL)
            return 3'd4;
        if (st[7:4] == HI_PROG || st[7:4] == HI_PRESS || st[7:4] == HI_BEND)
            return 3'd3;
        if (st == ST_LONG_CMD)
            return 3'd4;
        if (st == ST_SHORT_CMD)
            return 3'd2;
        return 3'd1;
    endfunction

    function automatic void clear_scan_state();
        sp_pos   = '0;
        sp_len   = '0;
        sp_is_cc = 1'b0;
        sp_ctrl  = '0;
        sp_bank  = '0;
        sp_banks = '0;
        sp_count = 0;
    endfunction

    // a command is complete: count it, mark its bank if it selects one
    function automatic void count_command();
        if (sp_is_cc && sp_ctrl == BANK_SELECT_CTRL)
            sp_banks[sp_bank] = 1'b1;
        sp_count++;
        sp_pos   = '0;
        sp_len   = '0;
        sp_is_cc = 1'b0;
    endfunction

    function automatic sbrs_pkg::result_t close_scan(sbrs_pkg::stop_cause_t cause);
        sbrs_pkg::result_t r;
        r.bank_map_low  = sp_banks[63:0];
        r.bank_map_high = sp_banks[127:64];
        r.commands_seen = sp_count[sbrs_pkg::CNT_W-1:0];
        r.stop_cause    = cause;
        sp_done         = 1'b1;
        return r;
    endfunction

    // advance the scan by one byte; returns 1 when the byte closes the scan
    function automatic bit scan_step(input sbrs_pkg::item_t it,
                                     output sbrs_pkg::result_t res, output bit live);
        logic [2:0] n;
        res  = '0;
        live = 1'b0;
        if (it.scan_start)
        begin
            clear_scan_state();
            sp_done = 1'b0;
        end
        if (sp_done)
            return 1'b0;
        live = 1'b1;
        // byte where a command would start
        if (sp_pos == 0)
        begin
            if (!it.in_region)
            begin
                res = close_scan(sbrs_pkg::CAUSE_REGION);
                return 1'b1;
            end
            if (sp_count >= sbrs_pkg::MAX_COMMANDS)
            begin
                res = close_scan(sbrs_pkg::CAUSE_LIMIT);
                return 1'b1;
            end
            if (it.data_byte == ST_END_MARKER)
            begin
                res = close_scan(sbrs_pkg::CAUSE_MARKER);
                return 1'b1;
            end
            n = command_bytes(it.data_byte);
            if (n == 3'd1)
            begin
                sp_is_cc = 1'b0;
                count_command();
                if (it.data_last)
                begin
                    res = close_scan(sbrs_pkg::CAUSE_REGION);
                    return 1'b1;
                end
                return 1'b0;
            end
            sp_len   = n;
            sp_is_cc = (it.data_byte[7:4] == HI_CTRL);
            sp_ctrl  = '0;
            sp_bank  = '0;
            sp_pos   = 3'd1;
            if (it.data_last)
            begin
                res = close_scan(sbrs_pkg::CAUSE_TRUNC);
                return 1'b1;
            end
            return 1'b0;
        end
        // byte inside a command
        if (sp_pos == 3'd1)
            sp_ctrl = it.data_byte;
        else if (sp_pos == 3'd2)
            sp_bank = it.data_byte[6:0];
        sp_pos = sp_pos + 3'd1;
        if (sp_pos >= sp_len)
        begin
            count_command();
            if (it.data_last)
            begin
                res = close_scan(sbrs_pkg::CAUSE_REGION);
                return 1'b1;
            end
            return 1'b0;
        end
        if (it.data_last)
        begin
            res = close_scan(sbrs_pkg::CAUSE_TRUNC);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one byte, wait for its transfer, then predict
    task automatic send_byte(input sbrs_pkg::item_t it);
        sbrs_pkg::result_t res;
        bit                live;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        if (scan_step(it, res, live))
            pending_summaries.insert(pending_summaries.size(), res);
        if (live)
            bytes_live++;
    endtask

    // stop offering and wait until every pending summary has arrived
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_summaries.size() != 0);
    endtask

    // receiver side: random stalls plus the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n || hold_active)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void note_failure(string what, sbrs_pkg::result_t want,
                                         sbrs_pkg::result_t got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display({"%0t: %s: expected map %h_%h cmds %0d cause %0d,",
                      " got map %h_%h cmds %0d cause %0d"},
                     $realtime, what, want.bank_map_high, want.bank_map_low, want.commands_seen,
                     want.stop_cause, got.bank_map_high, got.bank_map_low, got.commands_seen,
                     got.stop_cause);
    endfunction

    // summary check on each result transfer
    always @(posedge clk)
    begin
        sbrs_pkg::result_t want;
        string             bad;
        if (rst_n && result_valid && result_ready)
        begin
            scans_closed++;
            if (!$isunknown(result.stop_cause))
                cause_hits[result.stop_cause]++;
            if (pending_summaries.size() == 0)
                note_failure("summary with none pending", '0, result);
            else
            begin
                want = pending_summaries.pop_front();
                bad  = "";
                if (result.bank_map_low !== want.bank_map_low)
                    bad = {bad, " bank_map_low"};
                if (result.bank_map_high !== want.bank_map_high)
                    bad = {bad, " bank_map_high"};
                if (result.commands_seen !== want.commands_seen)
                    bad = {bad, " commands_seen"};
                if (result.stop_cause !== want.stop_cause)
                    bad = {bad, " stop_cause"};
                if (bad != "")
                    note_failure({"wrong", bad}, want, result);
            end
        end
    end

    function automatic logic [7:0] single_status();
        case ($urandom_range(0, 2))
            0:       return 8'h80;
            1:       return 8'($urandom_range(8'h84, 8'hAF));
            default: return 8'($urandom_range(8'hF0, 8'hFF));
        endcase
    endfunction

    function automatic cmd_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return CMD_BANK;
        if (r < 40)
            return CMD_CTRL;
        if (r < 55)
            return CMD_NOTE;
        if (r < 70)
            return CMD_THREE;
        if (r < 78)
            return CMD_LONG;
        if (r < 86)
            return CMD_SHORT;
        return CMD_SINGLE;
    endfunction

    // append one whole command with random content
    task automatic add_command(ref sbrs_pkg::item_t q[$], input cmd_kind_t k);
        logic [7:0] st;
        logic [7:0] b;
        int         n;
        case (k)
            CMD_NOTE:
            begin
                st = 8'($urandom_range(0, 127));
                n  = 5;
            end
            CMD_CTRL, CMD_BANK:
            begin
                st = {HI_CTRL, 4'($urandom)};
                n  = 4;
            end
            CMD_THREE:
            begin
                st = {4'(HI_PROG + $urandom_range(0, 2)), 4'($urandom)};
                n  = 3;
            end
            CMD_LONG:
            begin
                st = ST_LONG_CMD;
                n  = 4;
            end
            CMD_SHORT:
            begin
                st = ST_SHORT_CMD;
                n  = 2;
            end
            default:
            begin
                st = single_status();
                n  = 1;
            end
        endcase
        q = {q, make_item(st, 1'b0, 1'b1, 1'b0)};
        for (int i = 1; i < n; i++)
        begin
            b = (k == CMD_BANK && i == 1) ? BANK_SELECT_CTRL : 8'($urandom);
            q = {q, make_item(b, 1'b0, 1'($urandom), 1'b0)};
        end
    endtask

    // one well-formed scan with a random way of ending
    task automatic send_random_scan();
        sbrs_pkg::item_t scan_q[$];
        scan_end_t       how;
        cmd_kind_t       k;
        int              n_cmds;
        int              r;
        int              mark;
        int              keep;
        n_cmds = $urandom_range(0, 10);
        repeat (n_cmds)
            add_command(scan_q, pick_kind());
        r = $urandom_range(99);
        if (r < 25)
            how = END_MARKER;
        else if (r < 45)
            how = END_REGION;
        else if (r < 70)
            how = END_AT_LAST;
        else if (r < 90)
            how = END_TRUNC;
        else
            how = END_RESTART;
        if (n_cmds == 0 && (how == END_AT_LAST || how == END_RESTART))
            how = END_MARKER;
        case (how)
            END_MARKER:
                scan_q = {scan_q, make_item(ST_END_MARKER, 1'b0, 1'b1, 1'($urandom))};
            END_REGION:
                scan_q = {scan_q, make_item(8'($urandom), 1'b0, 1'b0, 1'($urandom))};
            END_AT_LAST:
                scan_q[scan_q.size()-1].data_last = 1'b1;
            END_TRUNC:
            begin
                do
                    k = pick_kind();
                while (k == CMD_SINGLE);
                mark = scan_q.size();
                add_command(scan_q, k);
                keep = $urandom_range(1, scan_q.size() - mark - 1);
                while (scan_q.size() > mark + keep)
                    void'(scan_q.pop_back());
                scan_q[scan_q.size()-1].data_last = 1'b1;
            end
            default: ;
        endcase
        scan_q[0].scan_start = 1'b1;
        foreach (scan_q[i])
            send_byte(scan_q[i]);
    endtask

    // bytes with every flag at random
    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_byte(make_item(8'($urandom), $urandom_range(99) < 10, 1'($urandom),
                                1'($urandom)));
    endtask

    // bytes before any start are dropped
    task automatic test_idle_bytes();
        send_byte(make_item(ST_END_MARKER, 1'b0, 1'b1, 1'b1));
        send_byte(make_item(8'hB0, 1'b0, 1'b0, 1'b0));
        drain();
    endtask

    // every command class, bank extremes and masking, ended by a marker on the last byte
    task automatic test_command_set();
        logic [7:0] seq_bytes[$];
        seq_bytes = '{8'hB0, 8'h20, 8'hFF, 8'h00,
                      8'hBF, 8'h20, 8'h00, 8'h55,
                      8'hB7, 8'h20, 8'hC0, 8'hAA,
                      8'hB1, 8'h1F, 8'h05, 8'h00,
                      8'h7F, 8'h11, 8'h22, 8'h33, 8'h44,
                      8'hC3, 8'h01, 8'h02,
                      8'hD9, 8'h03, 8'h04,
                      8'hEF, 8'h05, 8'h06,
                      8'h81, 8'h0A, 8'h0B, 8'h0C,
                      8'h82, 8'h0D,
                      8'h80, 8'hFF, 8'hA5, 8'hF0,
                      ST_END_MARKER};
        foreach (seq_bytes[i])
            send_byte(make_item(seq_bytes[i], i == 0, 1'b1, i == seq_bytes.size() - 1));
        drain();
    endtask

    // region end, data end at and inside commands, restart in the middle
    task automatic test_scan_endings();
        // region end on the very first byte
        send_byte(make_item(8'h90, 1'b1, 1'b0, 1'b0));
        // one-byte command that is also the last byte
        send_byte(make_item(8'h80, 1'b1, 1'b1, 1'b1));
        // bytes past the region end still belong to the open command
        send_byte(make_item(8'hC0, 1'b1, 1'b1, 1'b0));
        send_byte(make_item(8'h01, 1'b0, 1'b0, 1'b0));
        send_byte(make_item(8'h02, 1'b0, 1'b0, 1'b1));
        // data ends inside a note and inside a bank select
        send_byte(make_item(8'h00, 1'b1, 1'b1, 1'b0));
        send_byte(make_item(8'h12, 1'b0, 1'b1, 1'b0));
        send_byte(make_item(8'h34, 1'b0, 1'b1, 1'b1));
        send_byte(make_item(8'hB2, 1'b1, 1'b1, 1'b0));
        send_byte(make_item(BANK_SELECT_CTRL, 1'b0, 1'b1, 1'b0));
        send_byte(make_item(8'h05, 1'b0, 1'b1, 1'b1));
        send_byte(make_item(ST_SHORT_CMD, 1'b1, 1'b1, 1'b1));
        // restart drops the open scan and its bank
        send_byte(make_item(8'hB0, 1'b1, 1'b1, 1'b0));
        send_byte(make_item(BANK_SELECT_CTRL, 1'b0, 1'b1, 1'b0));
        send_byte(make_item(8'h7F, 1'b0, 1'b1, 1'b0));
        send_byte(make_item(ST_END_MARKER, 1'b1, 1'b1, 1'b1));
        // region end after a complete command
        send_byte(make_item(8'hE0, 1'b1, 1'b1, 1'b0));
        send_byte(make_item(8'h01, 1'b0, 1'b1, 1'b0));
        send_byte(make_item(8'h02, 1'b0, 1'b1, 1'b0));
        send_byte(make_item(8'h55, 1'b0, 1'b0, 1'b0));
        drain();
    endtask

    // receiver holds off while short scans keep arriving, so intake must stall
    task automatic test_backpressure();
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        repeat (10)
        begin
            send_byte(make_item(ST_END_MARKER, 1'b1, 1'b1, 1'b0));
            send_byte(make_item(single_status(), 1'b1, 1'b1, 1'b1));
        end
        drain();
    endtask

    // random scans through the traffic phases
    task automatic test_random_scans();
        int          phase_idle[4]  = '{0, 69, 0, 7};
        int          phase_stall[4] = '{0, 0, 69, 7};
        int unsigned goal;
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            goal      = bytes_live + RANDOM_ITEMS / 4;
            while (bytes_live < goal)
            begin
                if ($urandom_range(99) < 8)
                    send_noise();
                else
                    send_random_scan();
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_bytes();
        test_command_set();
        test_scan_endings();
        test_backpressure();
        test_random_scans();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d live bytes scanned, %0d summaries checked, %0d errors", bytes_live,
                 scans_closed, n_errors);
        $display("stops by region end %0d, end marker %0d, truncation %0d, command limit %0d",
                 cause_hits[sbrs_pkg::CAUSE_REGION], cause_hits[sbrs_pkg::CAUSE_MARKER],
                 cause_hits[sbrs_pkg::CAUSE_TRUNC], cause_hits[sbrs_pkg::CAUSE_LIMIT]);
        if (n_errors == 0 && pending_summaries.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d summaries pending", pending_summaries.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
